// ===== rtl/core/hcd_pkg.sv =====
// Shared constants, types and helpers for the Hadamard codeword decoder.
package hcd_pkg;

  localparam int MsgBits  = 6;
  localparam int Levels   = MsgBits - 1;
  localparam int Chips    = 1 << Levels;
  localparam int CodeW    = 32;
  localparam int MsgW     = 6;
  localparam int InDataW  = ((CodeW + 7) / 8) * 8;
  localparam int OutDataW = ((MsgW + 7) / 8) * 8;
  localparam int ChipBufW = (Chips > CodeW) ? Chips : CodeW;
  localparam int CorrW    = Levels + 2;
  localparam int MagW     = Levels + 1;
  localparam int IdxW     = Levels;
  localparam int Nodes    = Chips - 1;

  typedef logic signed [CorrW-1:0] corr_t;
  typedef corr_t corr_vec_t [Chips];

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic            nonpos;
    logic [IdxW-1:0] idx;
  } cand_t;

  function automatic int tree_off(input int s);
    return Chips - (Chips >> s);
  endfunction

  function automatic cand_t make_cand(input corr_t v, input int i);
    cand_t c;
    corr_t a;
    a        = (v < 0) ? -v : v;
    c.mag    = MagW'(a);
    c.nonpos = (v <= 0);
    c.idx    = IdxW'(i);
    return c;
  endfunction

  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.mag > a.mag) ? b : a;
  endfunction

endpackage

// ===== rtl/core/hcd_fht.sv =====
// Pipelined fast Walsh-Hadamard transform, one butterfly level per stage.
module hcd_fht (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hcd_pkg::CodeW-1:0]  codeword_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hcd_pkg::corr_vec_t         out_corr_o
);
  import hcd_pkg::*;

  logic [ChipBufW-1:0] chip_buf;
  logic [Chips-1:0]    chip_bits;
  corr_t               lvl_in  [Levels][Chips];
  corr_t               lvl_out [Levels][Chips];
  corr_t               data_q  [Levels][Chips];
  logic [Levels-1:0]   valid_q;
  logic [Levels-1:0]   stage_ready;

  assign chip_buf  = ChipBufW'(codeword_i);
  assign chip_bits = chip_buf[Chips-1:0];

  always_comb begin
    for (int c = 0; c < Chips; c++) begin
      lvl_in[0][c] = chip_bits[c] ? corr_t'(1) : {CorrW{1'b1}};
    end
    for (int s = 1; s < Levels; s++) begin
      for (int c = 0; c < Chips; c++) begin
        lvl_in[s][c] = data_q[s-1][c];
      end
    end
  end

  always_comb begin
    for (int s = 0; s < Levels; s++) begin
      for (int i = 0; i < Chips; i++) begin
        if ((i & (1 << s)) == 0) begin
          lvl_out[s][i] = lvl_in[s][i] + lvl_in[s][i + (1 << s)];
        end else begin
          lvl_out[s][i] = lvl_in[s][i - (1 << s)] - lvl_in[s][i];
        end
      end
    end
  end

  for (genvar s = 0; s < Levels; s++) begin : g_stage
    logic up_valid;
    logic down_ready;

    if (s == 0) begin : g_first
      assign up_valid = in_valid_i;
    end else begin : g_mid
      assign up_valid = valid_q[s-1];
    end

    if (s == Levels - 1) begin : g_last
      assign down_ready = out_ready_i;
    end else begin : g_inner
      assign down_ready = stage_ready[s+1];
    end

    assign stage_ready[s] = !valid_q[s] || down_ready;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (stage_ready[s]) begin
        valid_q[s] <= up_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_ready[s] && up_valid) begin
        for (int i = 0; i < Chips; i++) begin
          data_q[s][i] <= lvl_out[s][i];
        end
      end
    end
  end

  assign in_ready_o  = stage_ready[0];
  assign out_valid_o = valid_q[Levels-1];

  always_comb begin
    for (int i = 0; i < Chips; i++) begin
      out_corr_o[i] = data_q[Levels-1][i];
    end
  end

`ifndef NO_ASSERTIONS
  a_even_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_corr_o[0][0])
    else $error("odd correlation out of transform");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_corr_o[0]))
    else $error("transform output changed under stall");
`endif

endmodule

// ===== rtl/core/hcd_argmax.sv =====
// Pipelined compare tree that finds the largest absolute correlation.
module hcd_argmax (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hcd_pkg::corr_vec_t corr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hcd_pkg::cand_t     best_o
);
  import hcd_pkg::*;

  cand_t             leaf   [Chips];
  cand_t             node_d [Nodes];
  cand_t             node_q [Nodes];
  logic [Levels-1:0] valid_q;
  logic [Levels-1:0] stage_ready;

  always_comb begin
    for (int i = 0; i < Chips; i++) begin
      leaf[i] = make_cand(corr_i[i], i);
    end
    for (int j = 0; j < (Chips >> 1); j++) begin
      node_d[j] = pick(leaf[2*j], leaf[2*j+1]);
    end
    for (int s = 1; s < Levels; s++) begin
      for (int j = 0; j < (Chips >> (s + 1)); j++) begin
        node_d[tree_off(s) + j] = pick(node_q[tree_off(s-1) + 2*j],
                                       node_q[tree_off(s-1) + 2*j + 1]);
      end
    end
  end

  for (genvar s = 0; s < Levels; s++) begin : g_stage
    logic up_valid;
    logic down_ready;

    if (s == 0) begin : g_first
      assign up_valid = in_valid_i;
    end else begin : g_mid
      assign up_valid = valid_q[s-1];
    end

    if (s == Levels - 1) begin : g_last
      assign down_ready = out_ready_i;
    end else begin : g_inner
      assign down_ready = stage_ready[s+1];
    end

    assign stage_ready[s] = !valid_q[s] || down_ready;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (stage_ready[s]) begin
        valid_q[s] <= up_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_ready[s] && up_valid) begin
        for (int j = 0; j < (Chips >> (s + 1)); j++) begin
          node_q[tree_off(s) + j] <= node_d[tree_off(s) + j];
        end
      end
    end
  end

  assign in_ready_o  = stage_ready[0];
  assign out_valid_o = valid_q[Levels-1];
  assign best_o      = node_q[Nodes-1];

`ifndef NO_ASSERTIONS
  a_nonzero_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> best_o.mag != '0)
    else $error("winning correlation has zero magnitude");

  a_valid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_o))
    else $error("winner changed under stall");
`endif

endmodule

// ===== rtl/core/hadamard_codeword_decoder_unit.sv =====
// Top level of the biorthogonal Hadamard codeword decoder.
// Decodes one 32-chip hard-decision codeword per transfer into a 6-bit
// message: bits 4..0 are the best-matching Sylvester Hadamard row, bit 5 is
// set when that row correlates zero or negative; ties go to the lowest row.
// Throughput is one codeword per clock while the output is not stalled. A
// codeword passes through five pipelined butterfly levels of the fast
// Walsh-Hadamard transform, then five registered levels of the compare tree.
// Every stage holds under output backpressure, and empty stages still take
// new codewords while a finished result waits.
module hadamard_codeword_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hcd_pkg::InDataW-1:0]   s_axis_tdata,   // [31:0] codeword
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [hcd_pkg::OutDataW-1:0]  m_axis_tdata    // [5:0] message, [7:6] zero
);
  import hcd_pkg::*;

  logic             fht_valid;
  logic             fht_ready;
  corr_vec_t        fht_corr;
  cand_t            best;
  logic [MsgBits-1:0] msg_full;

  hcd_fht u_fht (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .codeword_i  (s_axis_tdata[CodeW-1:0]),
    .out_valid_o (fht_valid),
    .out_ready_i (fht_ready),
    .out_corr_o  (fht_corr)
  );

  hcd_argmax u_argmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fht_valid),
    .in_ready_o  (fht_ready),
    .corr_i      (fht_corr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .best_o      (best)
  );

  assign msg_full     = {best.nonpos, best.idx};
  assign m_axis_tdata = OutDataW'(MsgW'(msg_full));

`ifndef NO_ASSERTIONS
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a held result");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:MsgW] == '0)
    else $error("output padding not zero");

  a_fill_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("pipeline stalled with downstream ready");
`endif

endmodule
